>>> src/coo_spmm_pkg.sv
package coo_spmm_pkg;

    localparam int ROW_COUNT   = 1024;
    localparam int VEC_COUNT   = 32;
    localparam int TILE_DIM    = 64;

    localparam int MEM_DEPTH = ROW_COUNT * VEC_COUNT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LANE_W    = (VEC_COUNT > 1) ? $clog2(VEC_COUNT) : 1;
    localparam int CNT_W     = $clog2(VEC_COUNT + 1);

    localparam int CFG_W   = 6;
    localparam int VALUE_W = 32;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int FRAC_W  = 16;
    // y plus the shifted product, one guard bit
    localparam int SUM_W   = PROD_W - FRAC_W + 1;
    localparam int ROWS_W  = 11;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(32);

    typedef enum logic [1:0] {
        OP_WRITE_X = 2'd0,
        OP_WRITE_Y = 2'd1,
        OP_NONZERO = 2'd2,
        OP_READ_Y  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic [9:0]                row_base;
        logic [6:0]                row_local;
        logic [9:0]                col_base;
        logic [6:0]                col_local;
        logic [4:0]                lane;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        status_t                   status;
    } result_t;

    typedef struct packed {
        logic              capture;
        logic              write_x;
        logic              write_y;
        logic              read_y;
        logic              lane_issue;
        logic [LANE_W-1:0] lane_idx;
        logic              result_load;
        logic              result_from_y;
        status_t           result_status;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic range_bad;
        logic lanes_busy;
        logic saturated;
    } dp_status_t;

endpackage

>>> src/coo_spmm_ram.sv
module coo_spmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/coo_spmm_ctrl.sv
module coo_spmm_ctrl import coo_spmm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    output logic             result_valid,
    input  logic             result_stall,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    input  dp_status_t       dp_status,
    output ctrl_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [LANE_W-1:0] lane_reg, lane_next;
    logic [CFG_W-1:0]  active_reg, active_next;
    logic              out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]  lane_count;
    logic              last_lane;
    logic              can_load;

    // active lanes above the lane count clamp to it
    assign lane_count = (active_reg > VEC_COUNT) ? CNT_W'(VEC_COUNT) : CNT_W'(active_reg);
    assign last_lane  = (CNT_W'(lane_reg) + CNT_W'(1)) == lane_count;
    assign can_load   = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        active_next    = active_reg;
        cmd            = '0;

        cmd.lane_idx      = lane_reg;
        cmd.result_from_y = (dp_status.op == OP_READ_Y) && !dp_status.range_bad;
        if (dp_status.range_bad)
        begin
            cmd.result_status = ST_RANGE;
        end
        else if (dp_status.saturated)
        begin
            cmd.result_status = ST_SAT;
        end
        else
        begin
            cmd.result_status = ST_OK;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (!dp_status.range_bad)
                begin
                    unique case (dp_status.op)
                        OP_WRITE_X: cmd.write_x = 1'b1;
                        OP_WRITE_Y: cmd.write_y = 1'b1;
                        OP_READ_Y:  cmd.read_y  = 1'b1;
                        OP_NONZERO:
                        begin
                            if (lane_count != '0)
                            begin
                                lane_next  = '0;
                                state_next = S_RUN;
                            end
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_RUN:
            begin
                cmd.lane_issue = 1'b1;
                if (last_lane)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    lane_next = lane_reg + LANE_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!dp_status.lanes_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (can_load)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        priority if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (cfg_valid)
        begin
            active_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= '0;
            active_reg    <= ACTIVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

>>> src/coo_spmm_dp.sv
module coo_spmm_dp import coo_spmm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t dp_status,
    output result_t    result_data
);

    item_t                     item_reg;
    result_t                   result_reg;

    logic                      v1_reg, v2_reg;
    logic [LANE_W-1:0]         lane1_reg, lane2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VALUE_W-1:0] y1_reg;
    logic                      sat_reg;

    logic [ROWS_W-1:0]         row_sum, col_sum;
    logic                      nz_bad, elem_bad;
    logic [ADDR_W-1:0]         elem_addr, y_base, x_base;
    logic [ADDR_W-1:0]         y_lane_addr, x_lane_addr, y_wb_addr;

    logic signed [VALUE_W-1:0] x_rd_data, y_rd_data;
    logic signed [SUM_W-1:0]   sum;
    logic                      overflow;
    logic signed [VALUE_W-1:0] sum_sat;

    logic                      x_wr_en, y_wr_en, y_rd_en;
    logic [ADDR_W-1:0]         y_wr_addr, y_rd_addr;
    logic [VALUE_W-1:0]        y_wr_data;

    // address decode of the held item
    assign row_sum  = ROWS_W'(item_reg.row_base) + ROWS_W'(item_reg.row_local) - ROWS_W'(1);
    assign col_sum  = ROWS_W'(item_reg.col_base) + ROWS_W'(item_reg.col_local) - ROWS_W'(1);
    assign nz_bad   = (item_reg.row_local == '0) || (item_reg.row_local > TILE_DIM) ||
                      (item_reg.col_local == '0) || (item_reg.col_local > TILE_DIM) ||
                      (row_sum >= ROW_COUNT) || (col_sum >= ROW_COUNT);
    assign elem_bad = (item_reg.row_base >= ROW_COUNT) || (item_reg.lane >= VEC_COUNT);

    assign elem_addr   = ADDR_W'(ADDR_W'(item_reg.row_base) * VEC_COUNT) + ADDR_W'(item_reg.lane);
    assign y_base      = ADDR_W'(ADDR_W'(row_sum) * VEC_COUNT);
    assign x_base      = ADDR_W'(ADDR_W'(col_sum) * VEC_COUNT);
    assign y_lane_addr = y_base + ADDR_W'(cmd.lane_idx);
    assign x_lane_addr = x_base + ADDR_W'(cmd.lane_idx);
    assign y_wb_addr   = y_base + ADDR_W'(lane2_reg);

    // accumulate with saturation
    assign sum      = SUM_W'(y1_reg) + SUM_W'($signed(prod_reg[PROD_W-1:FRAC_W]));
    assign overflow = (sum[SUM_W-1:VALUE_W-1] != '0) && (sum[SUM_W-1:VALUE_W-1] != '1);
    always_comb
    begin
        if (!overflow)
        begin
            sum_sat = sum[VALUE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sum_sat = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    assign x_wr_en   = cmd.write_x;
    assign y_wr_en   = cmd.write_y || v2_reg;
    assign y_wr_addr = cmd.write_y ? elem_addr : y_wb_addr;
    assign y_wr_data = cmd.write_y ? item_reg.value : sum_sat;
    assign y_rd_en   = cmd.read_y || cmd.lane_issue;
    assign y_rd_addr = cmd.read_y ? elem_addr : y_lane_addr;

    coo_spmm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MEM_DEPTH)
    ) u_x_ram (
        .clk     (clk),
        .wr_en   (x_wr_en),
        .wr_addr (elem_addr),
        .wr_data (item_reg.value),
        .rd_en   (cmd.lane_issue),
        .rd_addr (x_lane_addr),
        .rd_data (x_rd_data)
    );

    coo_spmm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MEM_DEPTH)
    ) u_y_ram (
        .clk     (clk),
        .wr_en   (y_wr_en),
        .wr_addr (y_wr_addr),
        .wr_data (y_wr_data),
        .rd_en   (y_rd_en),
        .rd_addr (y_rd_addr),
        .rd_data (y_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sat_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.lane_issue;
            v2_reg <= v1_reg;
            if (cmd.capture)
            begin
                sat_reg <= 1'b0;
            end
            else if (v2_reg && overflow)
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item_data;
        end
        lane1_reg <= cmd.lane_idx;
        lane2_reg <= lane1_reg;
        prod_reg  <= item_reg.value * x_rd_data;
        y1_reg    <= y_rd_data;
        if (cmd.result_load)
        begin
            result_reg.read_value <= cmd.result_from_y ? y_rd_data : '0;
            result_reg.status     <= cmd.result_status;
        end
    end

    assign dp_status.op         = item_reg.op;
    assign dp_status.range_bad  = (item_reg.op == OP_NONZERO) ? nz_bad : elem_bad;
    assign dp_status.lanes_busy = v1_reg || v2_reg;
    assign dp_status.saturated  = sat_reg;
    assign result_data          = result_reg;

endmodule

>>> src/block_coo_spmm_accumulate.sv
// Sparse-times-dense multiply engine in Q16.16. Each word either writes one X or Y element,
// reads one Y element, or applies one nonzero: Y[row][l] += (coef * X[col][l]) >>> 16 over the
// active lanes, each sum saturating. One word is worked at a time. Element writes, reads,
// flagged words and nonzeros with no active lane go from decode straight to the finish state;
// a nonzero issues one lane per cycle through the shared multiplier, then waits in a writeback
// drain until the single Y write port has taken every lane. A finished result waits in the
// output register while the next word is taken; a stalled receiver holds a second finished
// word back for as long as it stalls.
// X and Y hold garbage after reset until written; there is no clearing pass.
module block_coo_spmm_accumulate import coo_spmm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    coo_spmm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .dp_status    (dp_status),
        .cmd          (cmd)
    );

    coo_spmm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_data   (item_data),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .result_data (result_data)
    );

`ifndef SYNTH
    // one word at a time: an accepted word stalls the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted back to back");

    // lanes only run for an in-range nonzero
    a_lane_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lane_issue |-> (dp_status.op == OP_NONZERO) && !dp_status.range_bad)
        else $error("lane issued for an illegal item");

    // result is not loaded while lane writebacks are still pending
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> !dp_status.lanes_busy)
        else $error("result loaded before lanes drained");

    // a new result appears only after a load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.result_load))
        else $error("result valid without load");
`endif

endmodule
